// ===== hw/rtl/oep_pkg.sv =====
`default_nettype none
package oep_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_GAIN_LL = 3'd0,
    REG_GAIN_LA = 3'd1,
    REG_GAIN_AL = 3'd2,
    REG_GAIN_AA = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dstep;
    logic signed [15:0] turn;
    logic [15:0]        heading_sum;
    logic               flip;
  } side_t;

  typedef struct packed {
    logic [15:0] ll;
    logic [15:0] la;
    logic [15:0] al;
    logic [15:0] aa;
  } gains_t;

  typedef struct packed {
    logic signed [31:0] next_x;
    logic signed [31:0] next_y;
    logic [15:0]        next_heading;
    logic signed [31:0] jac_x;
    logic signed [31:0] jac_y;
    logic [47:0]        noise_xx;
    logic signed [47:0] noise_xy;
    logic [47:0]        noise_yy;
    logic [47:0]        noise_heading;
  } res_t;

  function automatic logic [29:0] atan_at(input int idx);
    logic [29:0] v;
    case (idx)
      0: v = 30'd536870912;
      1: v = 30'd316933406;
      2: v = 30'd167458907;
      3: v = 30'd85004756;
      4: v = 30'd42667331;
      5: v = 30'd21354465;
      6: v = 30'd10680862;
      7: v = 30'd5340245;
      8: v = 30'd2670163;
      9: v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41721;
      15: v = 30'd20860;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2607;
      19: v = 30'd1303;
      20: v = 30'd651;
      21: v = 30'd325;
      22: v = 30'd162;
      23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/oep_cordic_stage.sv =====
`default_nettype none
module oep_cordic_stage
  import oep_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_valid,
  input  wire cordic_t in_cr,
  input  wire side_t   in_side,
  output logic         out_valid_r,
  output cordic_t      out_cr_r,
  output side_t        out_side_r
);

  logic signed [CW-1:0] xs, ys, at;
  cordic_t cr_nxt;

  always_comb begin
    xs = in_cr.x >>> IDX;
    ys = in_cr.y >>> IDX;
    at = $signed({{(CW-30){1'b0}}, atan_at(IDX)});
    if (!in_cr.z[CW-1]) begin
      cr_nxt.x = in_cr.x - ys;
      cr_nxt.y = in_cr.y + xs;
      cr_nxt.z = in_cr.z - at;
    end else begin
      cr_nxt.x = in_cr.x + ys;
      cr_nxt.y = in_cr.y - xs;
      cr_nxt.z = in_cr.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cr_r   <= cr_nxt;
      out_side_r <= in_side;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oep_post.sv =====
`default_nettype none
module oep_post
  import oep_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic    in_valid,
  input  wire cordic_t in_cr,
  input  wire side_t   in_side,
  input  wire gains_t  gains,
  output logic         out_valid_r,
  output res_t         out_res_r
);

  localparam logic signed [CW-1:0] ONE = 34'sd1073741824;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic [15:0]        hd;
    logic signed [31:0] jx;
    logic signed [31:0] jy;
  } pose_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic [7:0] v_r;

  // stage 1: sin/cos, gain products
  logic signed [CW-1:0] xc, yc, cw, sw;
  logic [32:0] ad_w;
  logic [16:0] at_w;
  logic signed [31:0] c1_r, s1_r, d1_r, px1_r, py1_r;
  logic [15:0] hd1_r;
  logic [47:0] agll1_r, agla1_r;
  logic [31:0] tgal1_r, tgaa1_r;

  always_comb begin
    xc = (in_cr.x > ONE) ? ONE : ((in_cr.x < -ONE) ? -ONE : in_cr.x);
    yc = (in_cr.y > ONE) ? ONE : ((in_cr.y < -ONE) ? -ONE : in_cr.y);
    cw = in_side.flip ? -xc : xc;
    sw = in_side.flip ? -yc : yc;
    ad_w = in_side.dstep[31] ? (33'd0 - {1'b1, in_side.dstep}) : {1'b0, in_side.dstep};
    at_w = in_side.turn[15] ? (17'd0 - {1'b1, in_side.turn}) : {1'b0, in_side.turn};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= cw[31:0];
      s1_r    <= sw[31:0];
      d1_r    <= in_side.dstep;
      px1_r   <= in_side.px;
      py1_r   <= in_side.py;
      hd1_r   <= in_side.heading_sum;
      agll1_r <= {16'd0, ad_w[31:0]} * {32'd0, gains.ll};
      agla1_r <= {16'd0, ad_w[31:0]} * {32'd0, gains.la};
      tgal1_r <= {16'd0, at_w[15:0]} * {16'd0, gains.al};
      tgaa1_r <= {16'd0, at_w[15:0]} * {16'd0, gains.aa};
    end
  end

  // stage 2: products
  logic signed [63:0] dc2_r, ds2_r, cc2_r, ss2_r;
  logic [63:0] cs2_r, tp1_2_r, tp2_2_r;
  logic cs_neg2_r;
  logic [31:0] cabs, sabs;
  logic signed [31:0] px2_r, py2_r;
  logic [15:0] hd2_r;
  logic [47:0] agll2_r, agla2_r;

  always_comb begin
    cabs = c1_r[31] ? 32'(-c1_r) : c1_r;
    sabs = s1_r[31] ? 32'(-s1_r) : s1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc2_r     <= 64'(d1_r) * 64'(c1_r);
      ds2_r     <= 64'(d1_r) * 64'(s1_r);
      cc2_r     <= 64'(c1_r) * 64'(c1_r);
      ss2_r     <= 64'(s1_r) * 64'(s1_r);
      cs2_r     <= {32'd0, cabs} * {32'd0, sabs};
      cs_neg2_r <= c1_r[31] ^ s1_r[31];
      tp1_2_r   <= {32'd0, tgal1_r} * {33'd0, PI_Q29};
      tp2_2_r   <= {32'd0, tgaa1_r} * {33'd0, PI_Q29};
      px2_r     <= px1_r;
      py2_r     <= py1_r;
      hd2_r     <= hd1_r;
      agll2_r   <= agll1_r;
      agla2_r   <= agla1_r;
    end
  end

  // stage 3: rounding, pose sums
  logic signed [63:0] rx, ry, rj;
  logic [63:0] c2w, s2w, csw, b1w, b2w;
  pose_t pose3_r;
  logic [30:0] c2_3_r, s2_3_r, csm3_r;
  logic cs_neg3_r;
  logic [47:0] op3_r [4];

  always_comb begin
    rx = (dc2_r + 64'sd536870912) >>> 30;
    ry = (ds2_r + 64'sd536870912) >>> 30;
    rj = ((-ds2_r) + 64'sd536870912) >>> 30;
    c2w = (64'(cc2_r) + 64'd536870912) >> 30;
    s2w = (64'(ss2_r) + 64'd536870912) >> 30;
    csw = (cs2_r + 64'd536870912) >> 30;
    b1w = (tp1_2_r + 64'd134217728) >> 28;
    b2w = (tp2_2_r + 64'd134217728) >> 28;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pose3_r.nx <= sat32(64'(px2_r) + rx);
      pose3_r.ny <= sat32(64'(py2_r) + ry);
      pose3_r.hd <= hd2_r;
      pose3_r.jx <= sat32(rj);
      pose3_r.jy <= sat32(rx);
      c2_3_r     <= c2w[30:0];
      s2_3_r     <= s2w[30:0];
      csm3_r     <= csw[30:0];
      cs_neg3_r  <= cs_neg2_r;
      op3_r[0]   <= agll2_r;
      op3_r[1]   <= b1w[47:0];
      op3_r[2]   <= b2w[47:0];
      op3_r[3]   <= agla2_r;
    end
  end

  // stage 4: square partial products
  logic [39:0] hh4_r [4];
  logic [39:0] hl4_r [4];
  logic [39:0] ll4_r [4];
  logic [3:0] sat4_r;
  pose_t pose4_r;
  logic [30:0] c2_4_r, s2_4_r, csm4_r;
  logic cs_neg4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        hh4_r[k]  <= {20'd0, op3_r[k][39:20]} * {20'd0, op3_r[k][39:20]};
        hl4_r[k]  <= {20'd0, op3_r[k][39:20]} * {20'd0, op3_r[k][19:0]};
        ll4_r[k]  <= {20'd0, op3_r[k][19:0]} * {20'd0, op3_r[k][19:0]};
        sat4_r[k] <= |op3_r[k][47:40];
      end
      pose4_r   <= pose3_r;
      c2_4_r    <= c2_3_r;
      s2_4_r    <= s2_3_r;
      csm4_r    <= csm3_r;
      cs_neg4_r <= cs_neg3_r;
    end
  end

  // stage 5: squares
  logic [61:0] rsum [4];
  logic [48:0] sqw [4];
  logic [47:0] sq5_r [4];
  pose_t pose5_r;
  logic [30:0] c2_5_r, s2_5_r, csm5_r;
  logic cs_neg5_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rsum[k] = ({21'd0, hl4_r[k], 1'b0} << 20) + {22'd0, ll4_r[k]};
      sqw[k]  = {1'b0, hh4_r[k], 8'd0} + 49'((62'(rsum[k]) + 62'd2147483648) >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        sq5_r[k] <= (sat4_r[k] || sqw[k][48]) ? SAT48 : sqw[k][47:0];
      end
      pose5_r   <= pose4_r;
      c2_5_r    <= c2_4_r;
      s2_5_r    <= s2_4_r;
      csm5_r    <= csm4_r;
      cs_neg5_r <= cs_neg4_r;
    end
  end

  // stage 6: variance sums
  logic [48:0] vl_w, va_w;
  logic [47:0] vl6_r, va6_r;
  pose_t pose6_r;
  logic [30:0] c2_6_r, s2_6_r, csm6_r;
  logic cs_neg6_r;

  always_comb begin
    vl_w = {1'b0, sq5_r[0]} + {1'b0, sq5_r[1]};
    va_w = {1'b0, sq5_r[2]} + {1'b0, sq5_r[3]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vl6_r     <= vl_w[48] ? SAT48 : vl_w[47:0];
      va6_r     <= va_w[48] ? SAT48 : va_w[47:0];
      pose6_r   <= pose5_r;
      c2_6_r    <= c2_5_r;
      s2_6_r    <= s2_5_r;
      csm6_r    <= csm5_r;
      cs_neg6_r <= cs_neg5_r;
    end
  end

  // stage 7: spreading partial products, order xx, xy, yy
  logic [30:0] fsel [3];
  logic [54:0] ma7_r [3];
  logic [54:0] mb7_r [3];
  logic [47:0] va7_r;
  pose_t pose7_r;
  logic cs_neg7_r;

  always_comb begin
    fsel[0] = c2_6_r;
    fsel[1] = csm6_r;
    fsel[2] = s2_6_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ma7_r[k] <= {31'd0, vl6_r[47:24]} * {24'd0, fsel[k]};
        mb7_r[k] <= {31'd0, vl6_r[23:0]} * {24'd0, fsel[k]};
      end
      va7_r     <= va6_r;
      pose7_r   <= pose6_r;
      cs_neg7_r <= cs_neg6_r;
    end
  end

  // stage 8: combine and output
  logic [55:0] low_w [3];
  logic [49:0] m_w [3];
  logic signed [47:0] xy_w;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      low_w[k] = {26'd0, ma7_r[k][5:0], 24'd0} + {1'b0, mb7_r[k]} + 56'd536870912;
      m_w[k]   = 50'(ma7_r[k] >> 6) + 50'(low_w[k] >> 30);
    end
    if (cs_neg7_r) begin
      xy_w = (m_w[1] > 50'h0_8000_0000_0000) ? 48'sh8000_0000_0000
                                             : 48'(-$signed(m_w[1]));
    end else begin
      xy_w = (m_w[1] > 50'h0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                             : $signed(m_w[1][47:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r.next_x        <= pose7_r.nx;
      out_res_r.next_y        <= pose7_r.ny;
      out_res_r.next_heading  <= pose7_r.hd;
      out_res_r.jac_x         <= pose7_r.jx;
      out_res_r.jac_y         <= pose7_r.jy;
      out_res_r.noise_xx      <= m_w[0][47:0];
      out_res_r.noise_xy      <= xy_w;
      out_res_r.noise_yy      <= m_w[2][47:0];
      out_res_r.noise_heading <= va7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  assign out_valid_r = v_r[7];

endmodule
`default_nettype wire

// ===== hw/rtl/odometry_ekf_prediction.sv =====
// channel | ports                          | direction | accepted when
// input   | in_valid, in_stall, in_*       | in        | in_valid && !in_stall
// output  | out_valid, out_stall, out_*    | out       | out_valid && !out_stall
// config  | cfg_we, cfg_index, cfg_data    | in        | cfg_we
// one word per cycle while the output is not stalled; registers in order: input register,
// one register per rotation step, eight arithmetic stages after the rotator
// synchronous active-low reset clears the valid bits and loads the default gains
// a stalled output freezes the whole pipeline; in_stall follows it in the same cycle
`default_nettype none
module odometry_ekf_prediction
  import oep_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pose_x,
  input  wire logic signed [31:0] in_pose_y,
  input  wire logic signed [15:0] in_pose_heading,
  input  wire logic signed [31:0] in_step_distance,
  input  wire logic signed [15:0] in_step_turn,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_next_x,
  output logic signed [31:0]      out_next_y,
  output logic signed [15:0]      out_next_heading,
  output logic signed [31:0]      out_jacobian_x_heading,
  output logic signed [31:0]      out_jacobian_y_heading,
  output logic [47:0]             out_noise_xx,
  output logic signed [47:0]      out_noise_xy,
  output logic [47:0]             out_noise_yy,
  output logic [47:0]             out_noise_heading,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  logic adv;
  gains_t gains_r;

  logic    v_w  [N+1];
  cordic_t cr_w [N+1];
  side_t   sd_w [N+1];

  logic [31:0] ang;
  logic flip;
  res_t res;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.ll <= 16'd2163;
      gains_r.la <= 16'd66;
      gains_r.al <= 16'd0;
      gains_r.aa <= 16'd2294;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_LL: gains_r.ll <= cfg_data;
        REG_GAIN_LA: gains_r.la <= cfg_data;
        REG_GAIN_AL: gains_r.al <= cfg_data;
        REG_GAIN_AA: gains_r.aa <= cfg_data;
        default: ;
      endcase
    end
  end

  // fold left half-plane onto the right one
  always_comb begin
    ang  = {in_pose_heading, 16'd0};
    flip = ang[31] ^ ang[30];
    if (flip) begin
      ang[31] = ~ang[31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_w[0] <= 1'b0;
    end else if (adv) begin
      v_w[0] <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr_w[0].x <= CORDIC_GAIN_Q30;
      cr_w[0].y <= '0;
      cr_w[0].z <= {{(CW-32){ang[31]}}, ang};
      sd_w[0].px <= in_pose_x;
      sd_w[0].py <= in_pose_y;
      sd_w[0].dstep <= in_step_distance;
      sd_w[0].turn <= in_step_turn;
      sd_w[0].heading_sum <= in_pose_heading + in_step_turn;
      sd_w[0].flip <= flip;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    oep_cordic_stage #(.IDX(i)) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .in_valid   (v_w[i]),
      .in_cr      (cr_w[i]),
      .in_side    (sd_w[i]),
      .out_valid_r(v_w[i+1]),
      .out_cr_r   (cr_w[i+1]),
      .out_side_r (sd_w[i+1])
    );
  end

  oep_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (v_w[N]),
    .in_cr      (cr_w[N]),
    .in_side    (sd_w[N]),
    .gains      (gains_r),
    .out_valid_r(out_valid),
    .out_res_r  (res)
  );

  assign out_next_x             = res.next_x;
  assign out_next_y             = res.next_y;
  assign out_next_heading       = res.next_heading;
  assign out_jacobian_x_heading = res.jac_x;
  assign out_jacobian_y_heading = res.jac_y;
  assign out_noise_xx           = res.noise_xx;
  assign out_noise_xy           = res.noise_xy;
  assign out_noise_yy           = res.noise_yy;
  assign out_noise_heading      = res.noise_heading;

endmodule
`default_nettype wire

// ===== hw/rtl/oep_checker.sv =====
`default_nettype none
module oep_props (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_next_x,
  input wire logic signed [15:0] out_next_heading,
  input wire logic [47:0]        out_noise_xx,
  input wire logic signed [47:0] out_noise_xy,
  input wire logic [47:0]        out_noise_heading
);

  // input side is held exactly while a finished word waits
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_x)
      && $stable(out_noise_heading) && $stable(out_next_heading))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // noise terms hold while the output word waits
  a_stalled_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_noise_xx) && $stable(out_noise_xy))
    else $error("noise terms moved under stall");

endmodule

bind odometry_ekf_prediction oep_props u_oep_props (.*);
`default_nettype wire

// ===== bench/oep_checker.sv =====
`timescale 1ns / 100ps
module oep_checker
  import oep_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] in_pose_x,
  input  wire logic signed [31:0] in_pose_y,
  input  wire logic signed [15:0] in_pose_heading,
  input  wire logic signed [31:0] in_step_distance,
  input  wire logic signed [15:0] in_step_turn,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_next_x,
  input  wire logic signed [31:0] out_next_y,
  input  wire logic signed [15:0] out_next_heading,
  input  wire logic signed [31:0] out_jacobian_x_heading,
  input  wire logic signed [31:0] out_jacobian_y_heading,
  input  wire logic [47:0]        out_noise_xx,
  input  wire logic signed [47:0] out_noise_xy,
  input  wire logic [47:0]        out_noise_yy,
  input  wire logic [47:0]        out_noise_heading,
  output int                      fails,
  output int                      pending
);

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [15:0] nh;
    logic [31:0] jx;
    logic [31:0] jy;
    logic [47:0] vxx;
    logic [47:0] vxy;
    logic [47:0] vyy;
    logic [47:0] vhh;
  } pose_pred_t;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int ROT_STEPS = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;

  longint rot_angle [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81
  };

  logic [15:0] g_ll, g_la, g_al, g_aa;
  pose_pred_t  pose_q[$];

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] sq_q32(input logic [63:0] a);
    logic [127:0] p;
    if (a >= (64'd1 << 40)) return {16'd0, SAT48};
    p = {64'd0, a} * {64'd0, a};
    p = (p + (128'd1 << 31)) >> 32;
    return (p > SAT48) ? {16'd0, SAT48} : p[63:0];
  endfunction

  function automatic logic [63:0] turn_q32(input logic [63:0] at, input logic [15:0] g);
    return (at * g * PI_Q29 + (64'd1 << 27)) >> 28;
  endfunction

  function automatic logic [47:0] scale_q30(input logic [63:0] v, input logic [63:0] f);
    logic [127:0] p;
    p = ({64'd0, v} * {64'd0, f} + (128'd1 << 29)) >> 30;
    return p[47:0];
  endfunction

  function automatic pose_pred_t predict_pose(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic [15:0] hd,
                                              input logic signed [31:0] dstep,
                                              input logic signed [15:0] turn);
    pose_pred_t r;
    logic [31:0] ang;
    logic flip, cs_neg;
    longint x, y, z, nx, c, s, pc, ps;
    logic [63:0] ad, at, vl, va, c2, s2, csm, t1, t2;
    logic [47:0] xym;
    ang = {hd, 16'h0};
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - rot_angle[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + rot_angle[i];
      end
      x = nx;
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    c = flip ? -x : x;
    s = flip ? -y : y;
    pc = (longint'(dstep) * c + (64'sd1 <<< 29)) >>> 30;
    ps = (longint'(dstep) * s + (64'sd1 <<< 29)) >>> 30;
    r.nx = clip32(longint'(px) + pc);
    r.ny = clip32(longint'(py) + ps);
    r.nh = hd + turn;
    r.jx = clip32((-(longint'(dstep) * s) + (64'sd1 <<< 29)) >>> 30);
    r.jy = clip32(pc);
    ad = (dstep < 0) ? -longint'(dstep) : longint'(dstep);
    at = (turn < 0) ? -longint'(turn) : longint'(turn);
    t1 = sq_q32(ad * g_ll);
    t2 = sq_q32(turn_q32(at, g_al));
    vl = t1 + t2;
    if (vl > SAT48) vl = SAT48;
    t1 = sq_q32(turn_q32(at, g_aa));
    t2 = sq_q32(ad * g_la);
    va = t1 + t2;
    if (va > SAT48) va = SAT48;
    c2 = (c * c + (64'sd1 <<< 29)) >>> 30;
    s2 = (s * s + (64'sd1 <<< 29)) >>> 30;
    cs_neg = (c < 0) != (s < 0);
    csm = (((c < 0) ? -c : c) * ((s < 0) ? -s : s) + (64'sd1 <<< 29)) >>> 30;
    xym = scale_q30(vl, csm);
    if (cs_neg)
      r.vxy = (xym > 48'h8000_0000_0000) ? 48'h8000_0000_0000 : -xym;
    else
      r.vxy = (xym > 48'h7fff_ffff_ffff) ? 48'h7fff_ffff_ffff : xym;
    r.vxx = scale_q30(vl, c2);
    r.vyy = scale_q30(vl, s2);
    r.vhh = va[47:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    pose_pred_t e;
    if (!rst_n) begin
      g_ll <= 16'd2163;
      g_la <= 16'd66;
      g_al <= 16'd0;
      g_aa <= 16'd2294;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_LL: g_ll <= cfg_data;
          REG_GAIN_LA: g_la <= cfg_data;
          REG_GAIN_AL: g_al <= cfg_data;
          REG_GAIN_AA: g_aa <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pose_q.push_back(predict_pose(in_pose_x, in_pose_y, in_pose_heading,
                                      in_step_distance, in_step_turn));
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t result word with nothing expected", $realtime);
          fails++;
        end else begin
          e = pose_q.pop_front();
          if (out_next_x !== e.nx) report("next_x", out_next_x, e.nx);
          if (out_next_y !== e.ny) report("next_y", out_next_y, e.ny);
          if (out_next_heading !== e.nh) report("next_heading", out_next_heading, e.nh);
          if (out_jacobian_x_heading !== e.jx)
            report("jacobian_x_heading", out_jacobian_x_heading, e.jx);
          if (out_jacobian_y_heading !== e.jy)
            report("jacobian_y_heading", out_jacobian_y_heading, e.jy);
          if (out_noise_xx !== e.vxx) report("noise_xx", out_noise_xx, e.vxx);
          if (out_noise_xy !== e.vxy) report("noise_xy", out_noise_xy, e.vxy);
          if (out_noise_yy !== e.vyy) report("noise_yy", out_noise_yy, e.vyy);
          if (out_noise_heading !== e.vhh) report("noise_heading", out_noise_heading, e.vhh);
        end
      end
      pending <= pose_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import oep_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int WATCH_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_pose_x = '0, in_pose_y = '0, in_step_distance = '0;
  logic signed [15:0] in_pose_heading = '0, in_step_turn = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_next_x, out_next_y, out_jacobian_x_heading, out_jacobian_y_heading;
  logic signed [15:0] out_next_heading;
  logic [47:0] out_noise_xx, out_noise_yy, out_noise_heading;
  logic signed [47:0] out_noise_xy;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fails, pending;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  bit burst_mode = 1'b0;

  always #1 clk = ~clk;

  odometry_ekf_prediction u_dut (.*);

  oep_checker u_chk (.*);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("odometry_ekf_prediction test failed");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold on request
  initial begin
    int mode;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 2);
      repeat (48) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if (hold_req) break;
      end
    end
  end

  int burst_left = 0;

  task automatic send_word(input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] hd, input logic [31:0] dstep,
                           input logic [15:0] turn);
    if (!burst_mode && burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_pose_x <= px;
    in_pose_y <= py;
    in_pose_heading <= hd;
    in_step_distance <= dstep;
    in_step_turn <= turn;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_gain(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return -$urandom_range(0, 32'h0008_0000);
      default: return $urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  function automatic logic [15:0] pick_turn();
    if ($urandom_range(0, 1)) return 16'($urandom);
    return 16'($urandom_range(0, 2048) - 1024);
  endfunction

  task automatic random_words(input int n);
    repeat (n)
      send_word($urandom, $urandom, 16'($urandom), pick_dist(), pick_turn());
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 32'h7fff_ffff, 16'h0000);
    send_word(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h7fff_ffff, 16'h8000);
    send_word(32'h8000_0000, 32'h7fff_ffff, 16'h4000, 32'h8000_0000, 16'h7fff);
    send_word(32'h0000_0000, 32'h0000_0000, 16'h4000, 32'h0001_0000, 16'h4000);
    send_word(32'h0001_0000, 32'hffff_0000, 16'hc000, 32'hffff_0000, 16'h8000);
    send_word(32'h0000_0000, 32'h0000_0000, 16'h7fff, 32'h0000_0000, 16'h0001);
    send_word(32'h0000_0000, 32'h0000_0000, 16'h2000, 32'hffff_ffff, 16'hffff);
    send_word(32'h1234_5678, 32'hedcb_a987, 16'h6000, 32'h0000_0001, 16'h0000);
    send_word(32'h0000_0000, 32'h0000_0000, 16'ha000, 32'h0100_0000, 16'h7fff);
    send_word(32'hffff_ffff, 32'h0000_0000, 16'hffff, 32'h0000_8000, 16'h8001);
    send_word(32'h7fff_0000, 32'h8000_ffff, 16'h3fff, 32'h7fff_ffff, 16'hc000);
    send_word(32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 32'haaaa_aaaa, 16'h5555);
    send_word(32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 32'h5555_5555, 16'haaaa);
    random_words(60);

    // long receiver hold while words keep coming
    burst_mode = 1'b1;
    hold_req = 1'b1;
    random_words(60);
    burst_mode = 1'b0;
    drain();

    write_gain(REG_GAIN_LL, 16'hffff);
    write_gain(REG_GAIN_LA, 16'hffff);
    write_gain(REG_GAIN_AL, 16'hffff);
    write_gain(REG_GAIN_AA, 16'hffff);
    write_gain(REG_UNUSED, 16'h0000);
    send_word(32'h0, 32'h0, 16'h2000, 32'h7fff_ffff, 16'h8000);
    send_word(32'h0, 32'h0, 16'he000, 32'h8000_0000, 16'h7fff);
    random_words(100);
    drain();

    write_gain(REG_GAIN_LL, 16'h0000);
    write_gain(REG_GAIN_LA, 16'h0000);
    write_gain(REG_GAIN_AL, 16'h0000);
    write_gain(REG_GAIN_AA, 16'h0000);
    random_words(60);
    drain();

    repeat (3) begin
      write_gain(REG_GAIN_LL, 16'($urandom));
      write_gain(REG_GAIN_LA, 16'($urandom));
      write_gain(REG_GAIN_AL, 16'($urandom));
      write_gain(REG_GAIN_AA, 16'($urandom));
      random_words(75);
      drain();
    end

    if (fails == 0)
      $display("odometry_ekf_prediction test passed");
    else
      $display("odometry_ekf_prediction test failed");
    $finish;
  end

endmodule

// ===== odometry_ekf_prediction.f =====
hw/rtl/oep_pkg.sv
hw/rtl/oep_cordic_stage.sv
hw/rtl/oep_post.sv
hw/rtl/odometry_ekf_prediction.sv
hw/rtl/oep_checker.sv
bench/oep_checker.sv
bench/tb.sv
